// ----- design/mme_pkg.sv -----
package mme_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 6;
    localparam int ELEM_IN_W  = 16;
    localparam int OUT_W      = 38;
    localparam int ACC_W      = OUT_W + 1;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_OF_A       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIMENSION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_OF_B       = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

// ----- design/mme_cmd_if.sv -----
interface mme_cmd_if;
    logic                               valid;
    logic                               ready;
    logic        [mme_pkg::OP_W-1:0]      operation;
    logic        [mme_pkg::IDX_W-1:0]     row_index;
    logic        [mme_pkg::IDX_W-1:0]     col_index;
    logic signed [mme_pkg::ELEM_IN_W-1:0] element_value;

    modport source (output valid, operation, row_index, col_index, element_value, input ready);
    modport sink   (input valid, operation, row_index, col_index, element_value, output ready);
endinterface

// ----- design/mme_rsp_if.sv -----
interface mme_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [mme_pkg::OUT_W-1:0] product_value;
    logic                           index_error;

    modport source (output valid, product_value, index_error, input ready);
    modport sink   (input valid, product_value, index_error, output ready);
endinterface

// ----- design/mme_csr_if.sv -----
interface mme_csr_if;
    logic                            valid;
    logic                            ready;
    logic [mme_pkg::CFG_ADDR_W-1:0]  index;
    logic [mme_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/mme_ram.sv -----
module mme_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/matrix_multiply_engine_core.sv -----
// Dense matrix multiply engine, C = A x B, signed Q8.8 elements and unrounded Q22.16 results.
// Elements of A and B are loaded one transaction at a time into two on-chip memories of
// MAX_DIM x MAX_DIM entries; a load gives no result. A compute transaction
// names (row, col) and yields one result: a single shared multiply-accumulate walks the inner
// dimension, reading one A and one B element per cycle. A compute passes through the read,
// multiply and accumulate stages, the drain check and the result load before the block takes
// the next transaction; an out-of-range index or a zero inner dimension goes straight to the
// result load, and the result load waits while the previous result is still in the output
// register. The input is not ready while a compute is in progress; a finished result is held in
// an output register and the next transaction is taken while it waits. Out-of-range loads are
// dropped; out-of-range computes return zero with index_error set. Configuration registers are
// written through the csr channel, which is always ready. Memory contents are undefined until
// written; there is no clearing pass.
module matrix_multiply_engine_core
#(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    mme_cmd_if.sink   cmd,
    mme_rsp_if.source rsp,
    mme_csr_if.sink   csr
);

    localparam int EW     = (ELEMENT_BITS > mme_pkg::ELEM_IN_W) ? mme_pkg::ELEM_IN_W : ELEMENT_BITS;
    localparam int PW     = 2 * EW;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = ($clog2(MAX_DIM + 1) > mme_pkg::CFG_W) ?
                            $clog2(MAX_DIM + 1) : mme_pkg::CFG_W;
    localparam int CW     = mme_pkg::CFG_W;
    localparam int OW     = mme_pkg::OUT_W;
    localparam int SUM_W  = PW + $clog2(MAX_DIM) + 1;
    localparam int AW     = (SUM_W > mme_pkg::ACC_W) ? SUM_W : mme_pkg::ACC_W;

    function automatic logic idx_in(input logic [mme_pkg::IDX_W-1:0] idx,
                                    input logic [CW-1:0] lim);
        idx_in = (CMP_W'(idx) < CMP_W'(lim)) && (CMP_W'(idx) < CMP_W'(MAX_DIM));
    endfunction

    mme_pkg::state_t state_reg, state_next;

    logic [CW-1:0] rows_reg, inner_reg, cols_reg;

    logic [ADDR_W-1:0]  a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]  b_addr_reg, b_addr_next;
    logic [CW-1:0]      nk_reg, nk_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               prod_vld_reg, prod_vld_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic               err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [OW-1:0] out_value_reg, out_value_next;
    logic               out_err_reg, out_err_next;

    logic              cmd_fire;
    logic              wr_a, wr_b, cmp_err;
    logic [CW-1:0]     nk_eff;
    logic [ADDR_W-1:0] wr_addr;
    logic [EW-1:0]     wr_data;
    logic              issue;
    logic [EW-1:0]     a_rd, b_rd;
    logic signed [OW-1:0] sat_value;

    assign cmd.ready = (state_reg == mme_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign csr.ready = 1'b1;

    assign wr_a = cmd_fire && (cmd.operation == mme_pkg::OP_WRITE_A) &&
                  idx_in(cmd.row_index, rows_reg) && idx_in(cmd.col_index, inner_reg);
    assign wr_b = cmd_fire && (cmd.operation == mme_pkg::OP_WRITE_B) &&
                  idx_in(cmd.row_index, inner_reg) && idx_in(cmd.col_index, cols_reg);
    assign cmp_err = !(idx_in(cmd.row_index, rows_reg) && idx_in(cmd.col_index, cols_reg));
    assign nk_eff  = (CMP_W'(inner_reg) > CMP_W'(MAX_DIM)) ? CW'(MAX_DIM) : inner_reg;

    assign wr_addr = ADDR_W'(32'(cmd.row_index) * MAX_DIM + 32'(cmd.col_index));
    assign wr_data = cmd.element_value[EW-1:0];
    assign issue   = (state_reg == mme_pkg::ST_RUN) && (cnt_reg != nk_reg);

    mme_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a
    (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd)
    );

    mme_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b
    (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd)
    );

    always_comb
    begin
        if ((&acc_reg[AW-1:OW-1]) || !(|acc_reg[AW-1:OW-1]))
        begin
            sat_value = acc_reg[OW-1:0];
        end
        else
        begin
            sat_value = acc_reg[AW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        nk_next        = nk_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rd_vld_next    = issue;
        prod_vld_next  = rd_vld_reg;
        prod_next      = $signed(a_rd) * $signed(b_rd);
        acc_next       = acc_reg;
        if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(AW - PW){prod_reg[PW-1]}}, prod_reg};
        end
        if (issue)
        begin
            a_addr_next = a_addr_reg + ADDR_W'(1);
            b_addr_next = b_addr_reg + ADDR_W'(MAX_DIM);
            cnt_next    = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (cmd_fire && (cmd.operation == mme_pkg::OP_COMPUTE))
                begin
                    acc_next    = '0;
                    err_next    = cmp_err;
                    nk_next     = nk_eff;
                    cnt_next    = '0;
                    a_addr_next = ADDR_W'(32'(cmd.row_index) * MAX_DIM);
                    b_addr_next = ADDR_W'(cmd.col_index);
                    if (cmp_err || (nk_eff == '0))
                    begin
                        state_next = mme_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = mme_pkg::ST_RUN;
                    end
                end
            end
            mme_pkg::ST_RUN:
            begin
                if (!issue && !rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = mme_pkg::ST_DONE;
                end
            end
            mme_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = err_reg ? '0 : sat_value;
                    out_err_next   = err_reg;
                    state_next     = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mme_pkg::ST_IDLE;
            rows_reg      <= mme_pkg::DIM_RESET;
            inner_reg     <= mme_pkg::DIM_RESET;
            cols_reg      <= mme_pkg::DIM_RESET;
            nk_reg        <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nk_reg        <= nk_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
            if (csr.valid && csr.ready)
            begin
                unique case (csr.index)
                    mme_pkg::REG_ROWS_OF_A:       rows_reg  <= csr.data;
                    mme_pkg::REG_INNER_DIMENSION: inner_reg <= csr.data;
                    mme_pkg::REG_COLS_OF_B:       cols_reg  <= csr.data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg    <= a_addr_next;
        b_addr_reg    <= b_addr_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.product_value = out_value_reg;
    assign rsp.index_error   = out_err_reg;

    a_prod_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(rd_vld_reg))
        else $error("product stage valid without a preceding memory read");

    a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == mme_pkg::ST_RUN))
        else $error("memory read outside the accumulate walk");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::ST_RUN) |-> (cnt_reg <= nk_reg))
        else $error("inner index ran past the inner dimension");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.index_error) |-> (rsp.product_value == '0))
        else $error("index error result carries a nonzero product");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mme_pkg::ST_DONE))
        else $error("result register loaded outside the completion state");

endmodule

// ----- tb/mme_gemm_checker.sv -----
`timescale 1ns / 1ps
module mme_gemm_checker
    import mme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mme_cmd_if   cmd,
    mme_rsp_if   rsp,
    mme_csr_if   csr,
    output int   mismatches,
    output int   outstanding
);

    localparam int     MAX_DIM = 64;
    localparam longint SUM_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< (OUT_W - 1));

    typedef struct packed
    {
        logic signed [OUT_W-1:0] product_value;
        logic                    index_error;
    } product_t;

    logic        [CFG_W-1:0]     rows_reg  = DIM_RESET;
    logic        [CFG_W-1:0]     inner_reg = DIM_RESET;
    logic        [CFG_W-1:0]     cols_reg  = DIM_RESET;
    logic signed [ELEM_IN_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_IN_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    product_t                    expected_products [$];
    int                          fail_count = 0;

    assign mismatches = fail_count;

    function automatic int active_dim(logic [CFG_W-1:0] value);
        return (int'(value) > MAX_DIM) ? MAX_DIM : int'(value);
    endfunction

    function automatic product_t predict_product(int row, int col);
        product_t res;
        longint   acc;
        int       inner;
        res.product_value = '0;
        res.index_error   = 1'b1;
        acc               = 0;
        inner             = active_dim(inner_reg);
        if (row >= active_dim(rows_reg) || col >= active_dim(cols_reg))
            return res;
        for (int k = 0; k < inner; k++)
            acc += longint'(a_mem[row*MAX_DIM + k]) * longint'(b_mem[k*MAX_DIM + col]);
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        if (acc < SUM_MIN)
            acc = SUM_MIN;
        res.product_value = acc[OUT_W-1:0];
        res.index_error   = 1'b0;
        return res;
    endfunction

    always @(posedge clk)
    begin
        product_t got;
        product_t want;
        int       row;
        int       col;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.product_value = rsp.product_value;
                got.index_error   = rsp.index_error;
                if (expected_products.size() == 0)
                begin
                    $error("unexpected result transaction: product_value %0d index_error %0b",
                           got.product_value, got.index_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (got.product_value !== want.product_value)
                    begin
                        $error("product_value mismatch: expected %0d, actual %0d",
                               want.product_value, got.product_value);
                        fail_count++;
                    end
                    if (got.index_error !== want.index_error)
                    begin
                        $error("index_error mismatch: expected %0b, actual %0b",
                               want.index_error, got.index_error);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                row = int'(cmd.row_index);
                col = int'(cmd.col_index);
                case (cmd.operation)
                    OP_WRITE_A:
                        if (row < active_dim(rows_reg) && col < active_dim(inner_reg))
                            a_mem[row*MAX_DIM + col] = cmd.element_value;
                    OP_WRITE_B:
                        if (row < active_dim(inner_reg) && col < active_dim(cols_reg))
                            b_mem[row*MAX_DIM + col] = cmd.element_value;
                    OP_COMPUTE:
                        expected_products.push_back(predict_product(row, col));
                    default:
                        ;
                endcase
            end
            if (csr.valid && csr.ready)
            begin
                case (csr.index)
                    REG_ROWS_OF_A:       rows_reg  = csr.data;
                    REG_INNER_DIMENSION: inner_reg = csr.data;
                    REG_COLS_OF_B:       cols_reg  = csr.data;
                    default:             ;
                endcase
            end
        end
        outstanding <= expected_products.size();
    end

endmodule

// ----- tb/tb_matrix_multiply_engine_core.sv -----
`timescale 1ns / 1ps
module tb_matrix_multiply_engine_core;

    import mme_pkg::*;

    localparam int              DIM            = 64;
    localparam logic [OP_W-1:0] OP_RESERVED    = 2'd3;
    localparam int              SETTLE_CYCLES  = 80;
    localparam int              WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   items_done     = 0;
    int   quiet_cycles   = 0;
    int   num_rows       = DIM;
    int   num_inner      = DIM;
    int   num_cols       = DIM;
    int   mismatches;
    int   outstanding;
    bit   a_set [DIM][DIM];
    bit   b_set [DIM][DIM];

    mme_cmd_if cmd();
    mme_rsp_if rsp();
    mme_csr_if csr();

    matrix_multiply_engine_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .csr   (csr)
    );

    mme_gemm_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .csr         (csr),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[matrix_multiply_engine_core] ERROR");
        $finish;
    end

    function automatic int clamp_dim(int value);
        return (value > DIM) ? DIM : value;
    endfunction

    // true when a compute at (row, col) reads only written elements
    function automatic bit covered(int row, int col);
        if (row >= num_rows || col >= num_cols)
            return 1'b1;
        for (int k = 0; k < num_inner; k++)
            if (!a_set[row][k] || !b_set[k][col])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_index(int limit);
        if (limit > 0 && $urandom_range(0, 7) != 0)
            return $urandom_range(0, limit - 1);
        return $urandom_range(0, DIM - 1);
    endfunction

    function automatic logic signed [ELEM_IN_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return ELEM_IN_W'($urandom);
        endcase
    endfunction

    task automatic hold_until_drained();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic configure(int rows, int inner, int cols);
        int                    values [3];
        logic [CFG_ADDR_W-1:0] regs   [3];
        values = '{rows, inner, cols};
        regs   = '{REG_ROWS_OF_A, REG_INNER_DIMENSION, REG_COLS_OF_B};
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            csr.valid <= 1'b1;
            csr.index <= regs[i];
            csr.data  <= CFG_W'(values[i]);
            do
                @(posedge clk);
            while (!csr.ready);
        end
        csr.valid <= 1'b0;
        num_rows  = clamp_dim(rows);
        num_inner = clamp_dim(inner);
        num_cols  = clamp_dim(cols);
    endtask

    task automatic issue(logic [OP_W-1:0] op, int row, int col,
                         logic signed [ELEM_IN_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.operation     <= op;
        cmd.row_index     <= IDX_W'(row);
        cmd.col_index     <= IDX_W'(col);
        cmd.element_value <= value;
        do
            @(posedge clk);
        while (!cmd.ready);
        case (op)
            OP_WRITE_A:
                if (row < num_rows && col < num_inner)
                    a_set[row][col] = 1'b1;
            OP_WRITE_B:
                if (row < num_inner && col < num_cols)
                    b_set[row][col] = 1'b1;
            default:
                ;
        endcase
        items_done++;
    endtask

    // load the unwritten (and some random) elements of one A row and one B column, then ask for products
    task automatic dot_product_sequence();
        int row;
        int col;
        int other_row;
        int other_col;
        row = pick_index(num_rows);
        col = pick_index(num_cols);
        if ($urandom_range(0, 29) == 0)
            hold_until_drained();
        for (int k = 0; k < num_inner; k++)
        begin
            if (!a_set[row][k] || $urandom_range(0, 3) == 0)
                issue(OP_WRITE_A, row, k, pick_element());
            if (!b_set[k][col] || $urandom_range(0, 3) == 0)
                issue(OP_WRITE_B, k, col, pick_element());
        end
        issue(OP_COMPUTE, row, col, pick_element());
        repeat ($urandom_range(0, 2))
        begin
            other_row = pick_index(num_rows);
            other_col = pick_index(num_cols);
            if (!covered(other_row, other_col))
            begin
                other_row = row;
                other_col = col;
            end
            issue(OP_COMPUTE, other_row, other_col, pick_element());
        end
    endtask

    task automatic noise_burst();
        logic [OP_W-1:0] op;
        int              row;
        int              col;
        repeat ($urandom_range(1, 4))
        begin
            op  = OP_W'($urandom_range(0, 3));
            row = $urandom_range(0, DIM - 1);
            col = $urandom_range(0, DIM - 1);
            if (op == OP_COMPUTE && !covered(row, col))
                op = $urandom_range(0, 1) ? OP_WRITE_A : OP_WRITE_B;
            issue(op, row, col, pick_element());
        end
    endtask

    task automatic run_phase(int rows, int inner, int cols, int send_pct, int stall_pct,
                             int target);
        configure(rows, inner, cols);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        items_done     = 0;
        while (items_done < target)
        begin
            if ($urandom_range(0, 3) == 0)
                noise_burst();
            else
                dot_product_sequence();
        end
    endtask

    task automatic run_directed();
        configure(DIM, 1, DIM);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue(OP_WRITE_A, 0, 0, 16'sh7FFF);
        issue(OP_WRITE_B, 0, 0, 16'sh7FFF);
        issue(OP_WRITE_A, DIM - 1, 0, 16'sh8000);
        issue(OP_WRITE_B, 0, DIM - 1, 16'sh8000);
        issue(OP_COMPUTE, 0, 0, 16'sh0000);
        issue(OP_COMPUTE, DIM - 1, DIM - 1, 16'shFFFF);
        issue(OP_COMPUTE, 0, DIM - 1, 16'sh0000);
        issue(OP_COMPUTE, DIM - 1, 0, 16'sh0000);
        // writes past the inner dimension are dropped
        issue(OP_WRITE_A, 5, 1, 16'sh0001);
        issue(OP_WRITE_B, 1, 5, 16'sh0001);
        issue(OP_RESERVED, DIM - 1, DIM - 1, 16'shFFFF);
        issue(OP_COMPUTE, DIM - 1, DIM - 1, 16'sh0000);
        issue(OP_WRITE_A, 0, 0, 16'sh0000);
        issue(OP_COMPUTE, 0, 0, 16'sh0000);
        issue(OP_WRITE_A, 0, 0, 16'shFFFF);
        issue(OP_WRITE_B, 0, 0, 16'shFFFF);
        issue(OP_COMPUTE, 0, 0, 16'sh0000);
        issue(OP_COMPUTE, 0, DIM - 1, 16'sh0000);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cmd.valid         <= 1'b0;
        cmd.operation     <= OP_WRITE_A;
        cmd.row_index     <= '0;
        cmd.col_index     <= '0;
        cmd.element_value <= '0;
        csr.valid         <= 1'b0;
        csr.index         <= REG_ROWS_OF_A;
        csr.data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(4, 4, 4, 0, 0, 250);
        run_phase(DIM, DIM, DIM, 76, 0, 220);
        run_phase(1, 1, 1, 0, 76, 180);
        run_phase(8, 0, 8, 32, 32, 150);
        run_phase(0, 5, 127, 0, 0, 120);
        run_phase(100, 16, 3, 76, 0, 250);
        run_phase(6, 127, 0, 0, 76, 150);
        run_phase(5, 3, 7, 32, 32, 250);
        run_phase(2, 2, 2, 0, 0, 280);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[matrix_multiply_engine_core] OK");
        else
            $display("[matrix_multiply_engine_core] ERROR");
        $finish;
    end

endmodule
